>>> src/rdsa_pkg.sv
// Shared types and constants for the radial distortion source address core.
// No dependencies; every other file refers to this package by scoped names.
package rdsa_pkg;

    // Largest image dimensions; larger register values are clamped to these
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W   = 13;    // image_width / image_height register width
    localparam int COORD_W = 12;    // dest_x / dest_y width
    localparam int T_W     = 14;    // centered doubled coordinate 2x - w
    localparam int COEF_W  = 32;    // Q4.28 register width
    localparam int KN_W    = 35;    // 1 - k1 - k2 - k3
    localparam int Q_W     = 48;    // signed Q.28 datapath word
    localparam int FRAC    = 28;    // fraction bits
    localparam int SRC_W   = 16;    // source coordinate width
    localparam int OFS_W   = 24;    // linear offset width
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Factor sum saturation bound, 2^47 - 1
    localparam logic signed [Q_W-1:0] QLIM = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [KN_W-1:0] ONE_Q28 = 35'sd268435456;

    // Delay from input transfer to result strobe
    localparam int LATENCY = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_ONE   = 3'd0,
        REG_COEF_TWO   = 3'd1,
        REG_COEF_THREE = 3'd2,
        REG_IMG_WIDTH  = 3'd3,
        REG_IMG_HEIGHT = 3'd4,
        REG_HORIZ_NORM = 3'd5,
        REG_VERT_NORM  = 3'd6
    } cfg_addr_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [KN_W-1:0]   kn;
        logic [DIM_W-1:0]         w;    // clamped width
        logic [DIM_W-1:0]         h;    // clamped height
        logic [COEF_W-1:0]        hn;
        logic [COEF_W-1:0]        vn;
    } cfg_t;

endpackage

>>> src/rdsa_cfg.sv
// Configuration register file: seven registers written over a valid/ready channel.
// Depends on rdsa_pkg; also derives the clamped dimensions and the constant term kn.
module rdsa_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rdsa_pkg::cfg_t                    cfg
);

    logic [rdsa_pkg::COEF_W-1:0] coef_one_reg;
    logic [rdsa_pkg::COEF_W-1:0] coef_two_reg;
    logic [rdsa_pkg::COEF_W-1:0] coef_three_reg;
    logic [rdsa_pkg::DIM_W-1:0]  width_reg;
    logic [rdsa_pkg::DIM_W-1:0]  height_reg;
    logic [rdsa_pkg::COEF_W-1:0] hnorm_reg;
    logic [rdsa_pkg::COEF_W-1:0] vnorm_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_one_reg   <= '0;
            coef_two_reg   <= '0;
            coef_three_reg <= '0;
            width_reg      <= 13'd4096;
            height_reg     <= 13'd4096;
            hnorm_reg      <= 32'd131072;
            vnorm_reg      <= 32'd131072;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rdsa_pkg::REG_COEF_ONE:   coef_one_reg   <= cfg_data;
                rdsa_pkg::REG_COEF_TWO:   coef_two_reg   <= cfg_data;
                rdsa_pkg::REG_COEF_THREE: coef_three_reg <= cfg_data;
                rdsa_pkg::REG_IMG_WIDTH:  width_reg      <= cfg_data[rdsa_pkg::DIM_W-1:0];
                rdsa_pkg::REG_IMG_HEIGHT: height_reg     <= cfg_data[rdsa_pkg::DIM_W-1:0];
                rdsa_pkg::REG_HORIZ_NORM: hnorm_reg      <= cfg_data;
                rdsa_pkg::REG_VERT_NORM:  vnorm_reg      <= cfg_data;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb
    begin
        cfg.k1 = $signed(coef_one_reg);
        cfg.k2 = $signed(coef_two_reg);
        cfg.k3 = $signed(coef_three_reg);
        cfg.kn = rdsa_pkg::ONE_Q28
               - rdsa_pkg::KN_W'($signed(coef_one_reg))
               - rdsa_pkg::KN_W'($signed(coef_two_reg))
               - rdsa_pkg::KN_W'($signed(coef_three_reg));
        cfg.w  = (width_reg > rdsa_pkg::DIM_W'(rdsa_pkg::MAX_WIDTH))
               ? rdsa_pkg::DIM_W'(rdsa_pkg::MAX_WIDTH) : width_reg;
        cfg.h  = (height_reg > rdsa_pkg::DIM_W'(rdsa_pkg::MAX_HEIGHT))
               ? rdsa_pkg::DIM_W'(rdsa_pkg::MAX_HEIGHT) : height_reg;
        cfg.hn = hnorm_reg;
        cfg.vn = vnorm_reg;
    end

endmodule

>>> src/rdsa_qmul.sv
// Four-stage pipelined Q.28 multiplier: truncates toward zero, saturates to +-(2^47 - 1).
// Depends on rdsa_pkg. Stages: magnitude, 24x24 partial products, sum, shift and saturate.
module rdsa_qmul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               vld_i,
    input  logic signed [rdsa_pkg::Q_W-1:0]    a,
    input  logic signed [rdsa_pkg::Q_W-1:0]    b,
    output logic                               vld_o,
    output logic signed [rdsa_pkg::Q_W-1:0]    p
);

    localparam int QW = rdsa_pkg::Q_W;
    localparam int HW = QW / 2;
    localparam int PW = 2 * QW;
    localparam int FR = rdsa_pkg::FRAC;

    logic [2:0]       vld_reg;
    logic             neg0_reg, neg1_reg, neg2_reg;
    logic [QW-1:0]    a_mag_reg, b_mag_reg;
    logic [QW-1:0]    ll_reg, lh_reg, hl_reg, hh_reg;
    logic [PW-1:0]    sum_reg;
    logic signed [QW-1:0] p_reg;
    logic             p_vld_reg;

    logic [QW-1:0]    a_mag_next, b_mag_next;
    logic [PW-1:0]    sum_next;
    logic             sat;
    logic [QW-2:0]    q;

    assign a_mag_next = a[QW-1] ? QW'(-a) : QW'(a);
    assign b_mag_next = b[QW-1] ? QW'(-b) : QW'(b);

    assign sum_next = (PW'(hh_reg) << QW) + (PW'(lh_reg) << HW)
                    + (PW'(hl_reg) << HW) + PW'(ll_reg);

    // saturate once the shifted product reaches 2^47
    assign sat = |sum_reg[PW-1:FR+QW-1];
    assign q   = sat ? {(QW-1){1'b1}} : sum_reg[FR+QW-2:FR];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= {vld_reg[1:0], vld_i};
            p_vld_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= a_mag_next;
        b_mag_reg <= b_mag_next;
        neg0_reg  <= a[QW-1] ^ b[QW-1];

        ll_reg   <= a_mag_reg[HW-1:0]  * b_mag_reg[HW-1:0];
        lh_reg   <= a_mag_reg[HW-1:0]  * b_mag_reg[QW-1:HW];
        hl_reg   <= a_mag_reg[QW-1:HW] * b_mag_reg[HW-1:0];
        hh_reg   <= a_mag_reg[QW-1:HW] * b_mag_reg[QW-1:HW];
        neg1_reg <= neg0_reg;

        sum_reg  <= sum_next;
        neg2_reg <= neg1_reg;

        p_reg <= neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    assign vld_o = p_vld_reg;
    assign p     = p_reg;

endmodule

>>> src/rdsa_coord.sv
// One axis of the source coordinate: trunc((t*F + d*2^28) / 2^29), saturated to 16 bits.
// Depends on rdsa_pkg. Three stages: split products, sum, truncate and saturate.
module rdsa_coord (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vld_i,
    input  logic signed [rdsa_pkg::T_W-1:0]     t,
    input  logic signed [rdsa_pkg::Q_W-1:0]     f,
    input  logic [rdsa_pkg::DIM_W-1:0]          d,
    output logic                                vld_o,
    output logic signed [rdsa_pkg::SRC_W-1:0]   s
);

    localparam int QW = rdsa_pkg::Q_W;
    localparam int HW = QW / 2;
    localparam int TW = rdsa_pkg::T_W;
    localparam int NW = 64;
    localparam int MW = NW - rdsa_pkg::FRAC - 1;
    localparam int SW = rdsa_pkg::SRC_W;

    logic [2:0]                 vld_reg;
    logic signed [TW+HW:0]      pl_reg;
    logic signed [TW+HW-1:0]    ph_reg;
    logic signed [NW-1:0]       num_reg;
    logic signed [SW-1:0]       s_reg;

    logic signed [TW+HW:0]      pl_next;
    logic signed [TW+HW-1:0]    ph_next;
    logic signed [NW-1:0]       num_next;
    logic [NW-1:0]              num_mag;
    logic [MW-1:0]              m;
    logic signed [SW-1:0]       s_next;

    assign pl_next = t * $signed({1'b0, f[HW-1:0]});
    assign ph_next = t * $signed(f[QW-1:HW]);

    assign num_next = (NW'(ph_reg) <<< HW) + NW'(pl_reg)
                    + $signed(NW'(d) << rdsa_pkg::FRAC);

    assign num_mag = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign m       = num_mag[NW-1:rdsa_pkg::FRAC+1];

    always_comb
    begin
        if (num_reg[NW-1])
        begin
            // negative side bottoms out at -32768
            if (m >= MW'(32768))
                s_next = {1'b1, {(SW-1){1'b0}}};
            else
                s_next = -$signed(m[SW-1:0]);
        end
        else
        begin
            if (m >= MW'(32767))
                s_next = {1'b0, {(SW-1){1'b1}}};
            else
                s_next = $signed(m[SW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], vld_i};
    end

    always_ff @(posedge clk)
    begin
        pl_reg  <= pl_next;
        ph_reg  <= ph_next;
        num_reg <= num_next;
        s_reg   <= s_next;
    end

    assign vld_o = vld_reg[2];
    assign s     = s_reg;

endmodule

>>> src/rdsa_addr.sv
// Range check and linear offset src_x + src_y*w, two stages, ending in the result registers.
// Depends on rdsa_pkg.
module rdsa_addr (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                vld_i,
    input  logic signed [rdsa_pkg::SRC_W-1:0]   sx,
    input  logic signed [rdsa_pkg::SRC_W-1:0]   sy,
    input  logic [rdsa_pkg::DIM_W-1:0]          w,
    input  logic [rdsa_pkg::DIM_W-1:0]          h,
    output logic                                done,
    output logic signed [rdsa_pkg::SRC_W-1:0]   src_x,
    output logic signed [rdsa_pkg::SRC_W-1:0]   src_y,
    output logic [rdsa_pkg::OFS_W-1:0]          src_offset,
    output logic                                in_range
);

    localparam int SW = rdsa_pkg::SRC_W;
    localparam int DW = rdsa_pkg::DIM_W;
    localparam int OW = rdsa_pkg::OFS_W;

    logic                   a_vld_reg;
    logic                   done_reg;
    logic signed [SW-1:0]   a_sx_reg, a_sy_reg;
    logic                   a_ok_reg;
    logic [OW-1:0]          a_prod_reg;
    logic signed [SW-1:0]   sx_reg, sy_reg;
    logic [OW-1:0]          offset_reg;
    logic                   ok_reg;

    logic                   ok_next;
    logic [SW+DW-2:0]       prod_full;
    logic [OW-1:0]          offset_next;

    assign ok_next = !sx[SW-1] && (sx[SW-2:0] < (SW-1)'(w))
                  && !sy[SW-1] && (sy[SW-2:0] < (SW-1)'(h));
    assign prod_full = sy[SW-2:0] * w;

    assign offset_next = a_ok_reg ? (OW'(a_sx_reg[SW-2:0]) + a_prod_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= vld_i;
            done_reg  <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sx_reg   <= sx;
        a_sy_reg   <= sy;
        a_ok_reg   <= ok_next;
        a_prod_reg <= prod_full[OW-1:0];

        sx_reg     <= a_sx_reg;
        sy_reg     <= a_sy_reg;
        offset_reg <= offset_next;
        ok_reg     <= a_ok_reg;
    end

    assign done       = done_reg;
    assign src_x      = sx_reg;
    assign src_y      = sy_reg;
    assign src_offset = offset_reg;
    assign in_range   = ok_reg;

endmodule

>>> src/radial_distortion_source_address_core.sv
// Top level of the radial distortion source address core.
// Depends on rdsa_pkg, rdsa_cfg, rdsa_qmul, rdsa_coord and rdsa_addr.
//
//   channel   direction  transfer when            payload
//   -------   ---------  -----------------------  -----------------------------------------
//   input     in         start && !busy           dest_x, dest_y
//   result    out        done (one-cycle strobe)  src_x, src_y, src_offset, in_range
//   config    in         cfg_valid && cfg_ready   cfg_index, cfg_data
//
// One pixel per clock; busy stays low and every start is taken.
// From transfer to done the path runs through the four chained four-stage
// Q.28 multiplier units (r^2 terms, r^4, r^6, k3*r^6) plus the centering,
// normalizing, r^2 sum, factor sum, coordinate and offset stages around them.
// Reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline advances every cycle.
module radial_distortion_source_address_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rdsa_pkg::COORD_W-1:0]        dest_x,
    input  logic [rdsa_pkg::COORD_W-1:0]        dest_y,
    output logic                                done,
    output logic signed [rdsa_pkg::SRC_W-1:0]   src_x,
    output logic signed [rdsa_pkg::SRC_W-1:0]   src_y,
    output logic [rdsa_pkg::OFS_W-1:0]          src_offset,
    output logic                                in_range,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rdsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdsa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int QW = rdsa_pkg::Q_W;
    localparam int TW = rdsa_pkg::T_W;
    localparam int T_LINE  = 20;    // centered coordinate to coordinate stage
    localparam int R2_LINE = 5;     // r2 to the r6 multiply
    localparam int P1_LINE = 8;     // k1*r2 to the factor sum
    localparam int P2_LINE = 4;     // k2*r4 to the factor sum

    rdsa_pkg::cfg_t cfg;

    logic                  accept;
    logic                  v1_reg, v2_reg, r2_vld_reg, f_vld_reg;
    logic signed [TW-1:0]  tx_line_reg [0:T_LINE-1];
    logic signed [TW-1:0]  ty_line_reg [0:T_LINE-1];
    logic signed [QW-1:0]  uu_reg, vv_reg;
    logic signed [QW-1:0]  r2_line_reg [0:R2_LINE-1];
    logic signed [QW-1:0]  p1_line_reg [0:P1_LINE-1];
    logic signed [QW-1:0]  p2_line_reg [0:P2_LINE-1];
    logic signed [QW-1:0]  f_reg;

    logic signed [TW-1:0]  tx_next, ty_next;
    logic signed [QW-1:0]  uu_next, vv_next;
    logic signed [QW:0]    r2_sum;
    logic signed [QW-1:0]  r2_next;
    logic signed [QW+2:0]  f_sum;
    logic signed [QW-1:0]  f_next;

    logic                  sq_u_vld, sq_v_vld, b_vld_a, b_vld_b, c_vld_a, c_vld_b, d_vld;
    logic signed [QW-1:0]  sq_u, sq_v, r4, p1, r6, p2, p3;
    logic                  cx_vld, cy_vld;
    logic signed [rdsa_pkg::SRC_W-1:0] sx, sy;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rdsa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // center: t = 2*coord - dimension
    assign tx_next = $signed({1'b0, dest_x, 1'b0}) - $signed({1'b0, cfg.w});
    assign ty_next = $signed({1'b0, dest_y, 1'b0}) - $signed({1'b0, cfg.h});

    // normalize: 2u and 2v in Q.28
    assign uu_next = QW'(tx_line_reg[0] * $signed({1'b0, cfg.hn}));
    assign vv_next = QW'(ty_line_reg[0] * $signed({1'b0, cfg.vn}));

    assign r2_sum  = {sq_u[QW-1], sq_u} + {sq_v[QW-1], sq_v};
    assign r2_next = QW'(r2_sum >>> 2);

    assign f_sum = (QW+3)'(cfg.kn) + (QW+3)'(p1_line_reg[P1_LINE-1])
                 + (QW+3)'(p2_line_reg[P2_LINE-1]) + (QW+3)'(p3);

    always_comb
    begin
        if (f_sum > (QW+3)'(rdsa_pkg::QLIM))
            f_next = rdsa_pkg::QLIM;
        else if (f_sum < -(QW+3)'(rdsa_pkg::QLIM))
            f_next = -rdsa_pkg::QLIM;
        else
            f_next = QW'(f_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            r2_vld_reg <= 1'b0;
            f_vld_reg  <= 1'b0;
        end
        else
        begin
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            r2_vld_reg <= sq_u_vld && sq_v_vld;
            f_vld_reg  <= d_vld;
        end
    end

    // payload and alignment lines advance every cycle
    always_ff @(posedge clk)
    begin
        tx_line_reg[0] <= tx_next;
        ty_line_reg[0] <= ty_next;
        for (int i = 1; i < T_LINE; i++)
        begin
            tx_line_reg[i] <= tx_line_reg[i-1];
            ty_line_reg[i] <= ty_line_reg[i-1];
        end

        uu_reg <= uu_next;
        vv_reg <= vv_next;

        r2_line_reg[0] <= r2_next;
        for (int i = 1; i < R2_LINE; i++)
            r2_line_reg[i] <= r2_line_reg[i-1];

        p1_line_reg[0] <= p1;
        for (int i = 1; i < P1_LINE; i++)
            p1_line_reg[i] <= p1_line_reg[i-1];

        p2_line_reg[0] <= p2;
        for (int i = 1; i < P2_LINE; i++)
            p2_line_reg[i] <= p2_line_reg[i-1];

        f_reg <= f_next;
    end

    // squares of the normalized coordinates
    rdsa_qmul u_sq_u (
        .clk (clk), .rst_n (rst_n), .vld_i (v2_reg),
        .a (uu_reg), .b (uu_reg), .vld_o (sq_u_vld), .p (sq_u)
    );

    rdsa_qmul u_sq_v (
        .clk (clk), .rst_n (rst_n), .vld_i (v2_reg),
        .a (vv_reg), .b (vv_reg), .vld_o (sq_v_vld), .p (sq_v)
    );

    // r4 and k1*r2
    rdsa_qmul u_r4 (
        .clk (clk), .rst_n (rst_n), .vld_i (r2_vld_reg),
        .a (r2_line_reg[0]), .b (r2_line_reg[0]), .vld_o (b_vld_a), .p (r4)
    );

    rdsa_qmul u_p1 (
        .clk (clk), .rst_n (rst_n), .vld_i (r2_vld_reg),
        .a (QW'(cfg.k1)), .b (r2_line_reg[0]), .vld_o (b_vld_b), .p (p1)
    );

    // r6 and k2*r4
    rdsa_qmul u_r6 (
        .clk (clk), .rst_n (rst_n), .vld_i (b_vld_a && b_vld_b),
        .a (r4), .b (r2_line_reg[R2_LINE-1]), .vld_o (c_vld_a), .p (r6)
    );

    rdsa_qmul u_p2 (
        .clk (clk), .rst_n (rst_n), .vld_i (b_vld_a && b_vld_b),
        .a (QW'(cfg.k2)), .b (r4), .vld_o (c_vld_b), .p (p2)
    );

    // k3*r6
    rdsa_qmul u_p3 (
        .clk (clk), .rst_n (rst_n), .vld_i (c_vld_a && c_vld_b),
        .a (QW'(cfg.k3)), .b (r6), .vld_o (d_vld), .p (p3)
    );

    rdsa_coord u_coord_x (
        .clk (clk), .rst_n (rst_n), .vld_i (f_vld_reg),
        .t (tx_line_reg[T_LINE-1]), .f (f_reg), .d (cfg.w),
        .vld_o (cx_vld), .s (sx)
    );

    rdsa_coord u_coord_y (
        .clk (clk), .rst_n (rst_n), .vld_i (f_vld_reg),
        .t (ty_line_reg[T_LINE-1]), .f (f_reg), .d (cfg.h),
        .vld_o (cy_vld), .s (sy)
    );

    rdsa_addr u_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .vld_i      (cx_vld && cy_vld),
        .sx         (sx),
        .sy         (sy),
        .w          (cfg.w),
        .h          (cfg.h),
        .done       (done),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_offset (src_offset),
        .in_range   (in_range)
    );

endmodule

>>> src/rdsa_checker.sv
// Port-level checks for the radial distortion source address core, bound to the top level.
// Depends on rdsa_pkg for the pipeline latency.
module rdsa_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic signed [rdsa_pkg::SRC_W-1:0]   src_x,
    input  logic signed [rdsa_pkg::SRC_W-1:0]   src_y,
    input  logic [rdsa_pkg::OFS_W-1:0]          src_offset,
    input  logic                                in_range
);

    localparam int LAT = rdsa_pkg::LATENCY;

    // every transfer yields a result after the fixed latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("input transfer not followed by a result");

    // no result without a matching transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching input transfer");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (src_offset == '0))
        else $error("nonzero offset for an out-of-range source");

    a_range_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_range) |-> (!src_x[rdsa_pkg::SRC_W-1] && !src_y[rdsa_pkg::SRC_W-1]))
        else $error("negative source coordinate flagged in range");

endmodule

bind radial_distortion_source_address_core rdsa_checker u_rdsa_checker (.*);
